// ===== src/jse_pkg.sv =====
// Shared types and character constants for the JSON string escape encoder.
package jse_pkg;

	// The three shapes an escaped run can take.
	typedef enum logic [1:0] {
		KIND_PLAIN   = 2'd0,
		KIND_PAIR    = 2'd1,
		KIND_UNICODE = 2'd2
	} kind_t;

	// One classified input byte as it travels from the front end to the back end.
	typedef struct packed {
		logic [7:0] raw;
		kind_t      kind;
		logic [7:0] esc;
		logic       last;
	} entry_t;

	localparam logic [7:0] CHR_QUOTE  = 8'h22;
	localparam logic [7:0] CHR_BSLASH = 8'h5C;
	localparam logic [7:0] CHR_DEL    = 8'h7F;
	localparam logic [7:0] CHR_CTRL_MAX = 8'h1F;
	localparam logic [7:0] CHR_U      = 8'h75;
	localparam logic [7:0] CHR_ZERO   = 8'h30;
	localparam logic [7:0] CHR_ONE    = 8'h31;
	localparam logic [7:0] CHR_SEVEN  = 8'h37;
	localparam logic [7:0] CHR_LC_A   = 8'h61;

	// Control bytes with a short two-character escape, and their escape letters.
	localparam logic [7:0] CHR_BACKSPACE = 8'h08;
	localparam logic [7:0] CHR_TAB       = 8'h09;
	localparam logic [7:0] CHR_NEWLINE   = 8'h0A;
	localparam logic [7:0] CHR_FORMFEED  = 8'h0C;
	localparam logic [7:0] CHR_RETURN    = 8'h0D;
	localparam logic [7:0] CHR_LC_B      = 8'h62;
	localparam logic [7:0] CHR_LC_F      = 8'h66;
	localparam logic [7:0] CHR_LC_N      = 8'h6E;
	localparam logic [7:0] CHR_LC_R      = 8'h72;
	localparam logic [7:0] CHR_LC_T      = 8'h74;

	// Position of the final byte in each kind of run.
	localparam logic [2:0] IDX_PLAIN_END   = 3'd0;
	localparam logic [2:0] IDX_PAIR_END    = 3'd1;
	localparam logic [2:0] IDX_UNICODE_END = 3'd5;

endpackage

// ===== src/jse_front.sv =====
// Front end: accepts input words and classifies each byte into an escape kind.
module jse_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,
	input  logic                s_tlast,
	output logic                push,
	output jse_pkg::entry_t     push_entry,
	input  logic                full
);

	logic            valid_s1;
	jse_pkg::entry_t entry_s1;

	function automatic jse_pkg::entry_t classify(input logic [7:0] b, input logic last);
		jse_pkg::entry_t e;
		e.raw  = b;
		e.last = last;
		e.esc  = b;
		e.kind = jse_pkg::KIND_PLAIN;
		if (b inside {jse_pkg::CHR_QUOTE, jse_pkg::CHR_BSLASH}) begin
			e.kind = jse_pkg::KIND_PAIR;
		end else if (b inside {[8'h00:jse_pkg::CHR_CTRL_MAX], jse_pkg::CHR_DEL}) begin
			e.kind = jse_pkg::KIND_PAIR;
			case (b)
				jse_pkg::CHR_BACKSPACE: e.esc = jse_pkg::CHR_LC_B;
				jse_pkg::CHR_FORMFEED:  e.esc = jse_pkg::CHR_LC_F;
				jse_pkg::CHR_NEWLINE:   e.esc = jse_pkg::CHR_LC_N;
				jse_pkg::CHR_RETURN:    e.esc = jse_pkg::CHR_LC_R;
				jse_pkg::CHR_TAB:       e.esc = jse_pkg::CHR_LC_T;
				default: e.kind = jse_pkg::KIND_UNICODE;
			endcase
		end
		return e;
	endfunction

	// The stage register frees up whenever its word moves into the queue.
	assign s_tready   = !valid_s1 || !full;
	assign push       = valid_s1;
	assign push_entry = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			entry_s1 <= classify(s_tdata, s_tlast);
		end
	end

endmodule

// ===== src/jse_queue.sv =====
// Short first-in first-out queue of classified bytes between front and back ends.
module jse_queue #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  jse_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output jse_pkg::entry_t head,
	output logic            empty
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	jse_pkg::entry_t  entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign head    = entries_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ===== src/jse_back.sv =====
// Back end: expands queue head into escaped run, one word per cycle unless stalled.
module jse_back (
	input  logic            clk,
	input  logic            arst_n,
	input  jse_pkg::entry_t head,
	input  logic            empty,
	output logic            pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [7:0]      m_tdata,
	output logic            m_tuser,
	output logic            m_tlast
);

	logic [2:0] idx_q;
	logic [2:0] end_idx;
	logic [7:0] next_byte;
	logic       can_load;
	logic       at_end;

	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		return (n < 4'd10) ? jse_pkg::CHR_ZERO + {4'd0, n}
		                   : jse_pkg::CHR_LC_A + {4'd0, n} - 8'd10;
	endfunction

	always_comb begin
		case (head.kind)
			jse_pkg::KIND_PAIR:    end_idx = jse_pkg::IDX_PAIR_END;
			jse_pkg::KIND_UNICODE: end_idx = jse_pkg::IDX_UNICODE_END;
			default:               end_idx = jse_pkg::IDX_PLAIN_END;
		endcase
	end

	always_comb begin
		case (idx_q)
			3'd0: next_byte = (head.kind == jse_pkg::KIND_PLAIN) ? head.raw
			                                                     : jse_pkg::CHR_BSLASH;
			3'd1: next_byte = (head.kind == jse_pkg::KIND_PAIR) ? head.esc : jse_pkg::CHR_U;
			3'd4: next_byte = hex_digit(head.raw[7:4]);
			3'd5: next_byte = hex_digit(head.raw[3:0]);
			default: next_byte = jse_pkg::CHR_ZERO;
		endcase
	end

	// The output register takes a new word whenever it is empty or being drained.
	assign can_load = !m_tvalid || m_tready;
	assign at_end   = (idx_q == end_idx);
	assign pop      = can_load && !empty && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			idx_q    <= '0;
		end else if (can_load) begin
			m_tvalid <= !empty;
			if (!empty) begin
				idx_q <= at_end ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && !empty) begin
			m_tdata <= next_byte;
			m_tuser <= at_end;
			m_tlast <= at_end && head.last;
		end
	end

endmodule

// ===== src/json_string_escape_encoder.sv =====
// Top level of the JSON string escape encoder: front end, queue and back end.
//
//   channel   direction  word contents
//   s_*       in         tdata[7:0] raw byte; tlast marks the final byte of the string
//   m_*       out        tdata[7:0] escaped byte; tuser run end; tlast string end
//
// One input word is taken per cycle while the queue has room; the first output
// word passes through the front stage register, the queue and the output register.
// Each input byte becomes a run of 1, 2 or 6 output words (plain, two-character
// escape, \u00XX escape); output runs at one word per cycle while m_tready is high.
// Reset is asynchronous and active low and clears all control state at once.
// Output stalls and multi-word runs fill the queue and then hold s_tready low.
module json_string_escape_encoder #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tuser,   // [0] run_last
	output logic       m_tlast
);

	logic            push;
	jse_pkg::entry_t push_entry;
	logic            full;
	logic            pop;
	jse_pkg::entry_t head;
	logic            empty;

	jse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.push       (push),
		.push_entry (push_entry),
		.full       (full)
	);

	jse_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.empty      (empty)
	);

	jse_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

`ifndef SYNTHESIS
	// The end of a string is always the end of a run.
	a_string_end_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("string end flagged on a word that is not a run end");

	// Only escape characters can appear inside an unfinished run.
	a_run_body: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata == jse_pkg::CHR_BSLASH || m_tdata == jse_pkg::CHR_U
			|| m_tdata == jse_pkg::CHR_ZERO || m_tdata == jse_pkg::CHR_ONE
			|| m_tdata == jse_pkg::CHR_SEVEN))
		else $error("unexpected byte inside an escape run");

	// Input backpressure only comes from a full queue behind an occupied front stage.
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> push && full && !empty)
		else $error("input stalled without a full queue");
`endif

endmodule

// ===== sim/json_string_escape_encoder_tb.sv =====
// Self-checking testbench for the JSON string escape encoder.
`timescale 1ns / 100ps

module json_string_escape_encoder_tb;

	localparam int RANDOM_ITEMS = 350;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 16;

	localparam logic [7:0] CHR_SPACE     = 8'h20;
	localparam logic [7:0] CHR_TILDE     = 8'h7E;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} raw_char_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       run_end;
		logic       str_end;
	} esc_char_t;

	logic       clk;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;
	logic       s_tlast  = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tuser;
	logic       m_tlast;

	raw_char_t raw_chars[$];
	esc_char_t escaped_chars[$];
	int        total_chars;
	int        chars_in      = 0;
	int        mismatches    = 0;
	int        quiet_cycles  = 0;
	int        stream_phase;

	json_string_escape_encoder uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Sender and receiver slow down in turns, then both run flat out for the last third.
	assign stream_phase = (total_chars == 0) ? 0 : (chars_in * 3) / total_chars;

	// Appends the escaped run for one input byte to the expected output.
	function automatic void escape_char(input logic [7:0] ch, input logic last);
		logic [7:0] seq [6];
		int         len;
		logic [3:0] nib;
		logic [7:0] letter;
		esc_char_t  w;

		letter = 8'h00;
		case (ch)
			jse_pkg::CHR_BACKSPACE: letter = jse_pkg::CHR_LC_B;
			jse_pkg::CHR_TAB:       letter = jse_pkg::CHR_LC_T;
			jse_pkg::CHR_NEWLINE:   letter = jse_pkg::CHR_LC_N;
			jse_pkg::CHR_FORMFEED:  letter = jse_pkg::CHR_LC_F;
			jse_pkg::CHR_RETURN:    letter = jse_pkg::CHR_LC_R;
			default:                letter = 8'h00;
		endcase

		if (ch == jse_pkg::CHR_QUOTE || ch == jse_pkg::CHR_BSLASH) begin
			seq[0] = jse_pkg::CHR_BSLASH;
			seq[1] = ch;
			len = 2;
		end else if (ch > jse_pkg::CHR_CTRL_MAX && ch != jse_pkg::CHR_DEL) begin
			seq[0] = ch;
			len = 1;
		end else if (letter != 8'h00) begin
			seq[0] = jse_pkg::CHR_BSLASH;
			seq[1] = letter;
			len = 2;
		end else begin
			seq[0] = jse_pkg::CHR_BSLASH;
			seq[1] = jse_pkg::CHR_U;
			seq[2] = jse_pkg::CHR_ZERO;
			seq[3] = jse_pkg::CHR_ZERO;
			for (int i = 0; i < 2; i++) begin
				nib = (i == 0) ? ch[7:4] : ch[3:0];
				seq[4 + i] = (nib < 4'd10) ? jse_pkg::CHR_ZERO + nib
				                           : jse_pkg::CHR_LC_A + nib - 8'd10;
			end
			len = 6;
		end

		for (int k = 0; k < len; k++) begin
			w.ch      = seq[k];
			w.run_end = (k == len - 1);
			w.str_end = (k == len - 1) && last;
			escaped_chars = {escaped_chars, w};
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Driver: a new word is offered only once the current one has been taken.
	always @(posedge clk) begin
		int        gap_pct;
		raw_char_t c;

		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				escape_char(s_tdata, s_tlast);
				chars_in++;
			end
			gap_pct = (stream_phase == 0) ? 32 : (stream_phase == 1) ? 82 : 0;
			if (!s_tvalid || s_tready) begin
				if (raw_chars.size() != 0 && $urandom_range(99) >= gap_pct) begin
					c = raw_chars[0];
					raw_chars.delete(0);
					s_tvalid <= 1'b1;
					s_tdata  <= c.ch;
					s_tlast  <= c.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: every accepted output word is checked against the oldest expected one.
	always @(posedge clk) begin
		int        stall_pct;
		esc_char_t w;

		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (escaped_chars.size() == 0) begin
					$error("unexpected output word: out_byte %h", m_tdata);
					mismatches++;
				end else begin
					w = escaped_chars[0];
					escaped_chars.delete(0);
					if (m_tdata !== w.ch) begin
						$error("out_byte mismatch: expected %h, got %h", w.ch, m_tdata);
						mismatches++;
					end
					if (m_tuser !== w.run_end) begin
						$error("run_last mismatch: expected %b, got %b", w.run_end, m_tuser);
						mismatches++;
					end
					if (m_tlast !== w.str_end) begin
						$error("string_last mismatch: expected %b, got %b", w.str_end, m_tlast);
						mismatches++;
					end
				end
			end
			stall_pct = (stream_phase == 0) ? 82 : (stream_phase == 1) ? 32 : 0;
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog: too long without any word moving on either side means the block hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0] directed [] = '{8'h00, jse_pkg::CHR_CTRL_MAX, jse_pkg::CHR_DEL,
			jse_pkg::CHR_QUOTE, jse_pkg::CHR_BSLASH, jse_pkg::CHR_BACKSPACE,
			jse_pkg::CHR_FORMFEED, jse_pkg::CHR_NEWLINE, jse_pkg::CHR_RETURN,
			jse_pkg::CHR_TAB, 8'h01, 8'h1A, 8'h10, 8'h0B, CHR_SPACE, 8'h41, CHR_TILDE,
			8'h80, 8'hFF, 8'hAA, 8'h55};
		raw_char_t c;

		foreach (directed[i]) begin
			c.ch   = directed[i];
			c.last = (i % 4 == 3) || (i == directed.size() - 1);
			raw_chars = {raw_chars, c};
		end

		// Mostly text and escapable characters, with the full byte range mixed in.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			case ($urandom_range(9))
				0, 1, 2, 3: c.ch = 8'($urandom_range(CHR_TILDE, CHR_SPACE));
				4, 5:       c.ch = ($urandom_range(7) == 0) ? jse_pkg::CHR_DEL
				                   : 8'($urandom_range(jse_pkg::CHR_CTRL_MAX));
				6:          c.ch = ($urandom_range(1) == 0) ? jse_pkg::CHR_QUOTE
				                                            : jse_pkg::CHR_BSLASH;
				default:    c.ch = 8'($urandom_range(255));
			endcase
			c.last = ($urandom_range(7) == 0);
			raw_chars = {raw_chars, c};
		end
		total_chars = raw_chars.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (chars_in < total_chars) @(posedge clk);
		while (escaped_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
